// File: sv/imu_fp_pkg.sv
// package for the imu frame parser: frame constants, result type, kind decode
// no dependencies; imported by every module of the parser
package imu_fp_pkg;

    localparam int ByteW      = 8;
    localparam int WordW      = 16;
    localparam int StoreDepth = 9;
    localparam int IdxW       = 4;

    localparam logic [ByteW-1:0] HeaderByte = 8'h55;
    localparam logic [ByteW-1:0] TypeAccel  = 8'h51;
    localparam logic [ByteW-1:0] TypeRate   = 8'h52;
    localparam logic [ByteW-1:0] TypeAngle  = 8'h53;
    localparam logic [IdxW-1:0]  CheckPos   = 4'd10;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2,
        KIND_OTHER = 2'd3
    } frame_kind_t;

    // decoded frame as handed to the output register
    typedef struct packed {
        frame_kind_t              frame_kind;
        logic [ByteW-1:0]         type_byte;
        logic signed [WordW-1:0]  axis_x;
        logic signed [WordW-1:0]  axis_y;
        logic signed [WordW-1:0]  axis_z;
        logic signed [WordW-1:0]  temp_raw;
    } frame_res_t;

    // collector status seen by the top level
    typedef struct packed {
        logic [IdxW-1:0] byte_index;
        logic            check_step;
    } coll_status_t;

    function automatic frame_kind_t kind_of(input logic [ByteW-1:0] t);
        frame_kind_t k;
        unique case (t)
            TypeAccel: k = KIND_ACCEL;
            TypeRate:  k = KIND_RATE;
            TypeAngle: k = KIND_ANGLE;
            default:   k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

// File: sv/imu_fp_collect.sv
// input byte register, header hunt, running sum, frame byte store and decode
// depends on imu_fp_pkg
module imu_fp_collect (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               rx_byte,
    input  logic                     advance,
    output logic                     res_valid,
    output imu_fp_pkg::frame_res_t   res,
    output imu_fp_pkg::coll_status_t status
);
    import imu_fp_pkg::*;

    logic             byte_valid_reg;
    logic [ByteW-1:0] byte_reg;
    logic [IdxW-1:0]  idx_reg, idx_next;
    logic [ByteW-1:0] sum_reg, sum_next;
    logic [ByteW-1:0] store_reg [StoreDepth];
    logic             proc;
    logic             hunting;
    logic             check_step;
    logic             store_we;

    assign in_ready = !byte_valid_reg || advance;
    assign proc     = byte_valid_reg && advance;

    // input byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            byte_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            byte_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    // frame position and checksum update
    always_comb
    begin
        hunting    = (idx_reg == '0) && (byte_reg != HeaderByte);
        check_step = (idx_reg >= CheckPos);
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        res_valid  = 1'b0;
        store_we   = 1'b0;
        if (proc && !hunting)
        begin
            if (check_step)
            begin
                idx_next  = '0;
                sum_next  = '0;
                res_valid = (byte_reg == sum_reg);
            end
            else
            begin
                sum_next = sum_reg + byte_reg;
                idx_next = idx_reg + 1'b1;
                store_we = (idx_reg != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            sum_reg <= sum_next;
        end
    end

    // frame bytes 1 to 9, entry i holds byte i+1
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < StoreDepth; i++)
        begin
            if (store_we && (idx_reg == IdxW'(i + 1)))
            begin
                store_reg[i] <= byte_reg;
            end
        end
    end

    // decode from the stored frame
    always_comb
    begin
        res.frame_kind = kind_of(store_reg[0]);
        res.type_byte  = store_reg[0];
        res.axis_x     = {store_reg[2], store_reg[1]};
        res.axis_y     = {store_reg[4], store_reg[3]};
        res.axis_z     = {store_reg[6], store_reg[5]};
        res.temp_raw   = {store_reg[8], store_reg[7]};
    end

    assign status.byte_index = idx_reg;
    assign status.check_step = proc && check_step;

endmodule

// File: sv/imu_fp_out.sv
// result register toward the output channel
// depends on imu_fp_pkg
module imu_fp_out (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_valid,
    input  imu_fp_pkg::frame_res_t res,
    output logic                   advance,
    output logic                   out_valid,
    input  logic                   out_ready,
    output imu_fp_pkg::frame_res_t out_res
);
    import imu_fp_pkg::*;

    logic       out_valid_reg;
    frame_res_t out_res_reg;

    // pipeline moves whenever the result slot is free or being drained
    assign advance = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// File: sv/imu_frame_parser.sv
// top level of the imu serial frame parser
// depends on imu_fp_pkg, imu_fp_collect and imu_fp_out
//
// Input channel: one received serial byte per request on rx_byte, with
// in_valid / in_ready. Bytes are dropped until a 0x55 header; then an
// 11-byte frame is collected with an 8-bit sum over its first ten bytes.
// Output channel: one decoded frame per request (frame_kind, type_byte,
// axis_x/y/z, temp_raw) with out_valid / out_ready, only when the 11th
// byte matches the sum; a mismatching frame is dropped without output.
// Throughput: one byte per cycle while the result register is free or being drained.
// Path: the checksum byte is held in the input byte register, and its result
// is loaded into the result register, raising out_valid, once that slot is
// free or being drained.
// Reset: rst_n clears the byte register valid, frame position, sum and
// result valid; the block starts hunting for a header.
// Stall: while out_valid is high and out_ready low, the held byte waits and
// in_ready drops once the input register is full; no byte is lost.
module imu_frame_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          frame_kind,
    output logic [7:0]          type_byte,
    output logic signed [15:0]  axis_x,
    output logic signed [15:0]  axis_y,
    output logic signed [15:0]  axis_z,
    output logic signed [15:0]  temp_raw
);
    import imu_fp_pkg::*;

    logic         advance;
    logic         res_valid;
    frame_res_t   res;
    frame_res_t   out_res;
    coll_status_t status;

    // byte collection and frame decode
    imu_fp_collect u_collect (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    // result register
    imu_fp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign frame_kind = out_res.frame_kind;
    assign type_byte  = out_res.type_byte;
    assign axis_x     = out_res.axis_x;
    assign axis_y     = out_res.axis_y;
    assign axis_z     = out_res.axis_z;
    assign temp_raw   = out_res.temp_raw;

`ifndef SYNTHESIS
    // frame position never passes the checksum byte
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.byte_index <= CheckPos)
        else $error("frame position out of range");

    // a result only comes from a checksum byte
    a_res_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> status.check_step)
        else $error("result without checksum byte");

    // a checksum byte sends the parser back to hunting
    a_check_resets: assert property (@(posedge clk) disable iff (!rst_n)
        status.check_step |=> status.byte_index == '0)
        else $error("frame position not cleared after checksum");

    // an empty result slot never blocks the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result slot");
`endif

endmodule

// File: tb/sv/tb_imu_frame_parser.sv
// testbench for imu_frame_parser: byte stream stimulus, frame decode prediction, result checks
// depends on imu_fp_pkg and the imu_frame_parser rtl
module tb_imu_frame_parser;

    import imu_fp_pkg::*;

    // tracks the parser state from accepted bytes and holds the decoded frames still due
    class frame_checker;
        logic [3:0]  byte_pos;
        logic [7:0]  frame_sum;
        logic [7:0]  frame_bytes [StoreDepth];
        frame_res_t  expected_frames [$];
        int          mismatches;

        function new();
            byte_pos   = '0;
            frame_sum  = '0;
            mismatches = 0;
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
        endfunction

        // advance the frame tracker by one accepted byte
        function void note_rx_byte(logic [7:0] b);
            frame_res_t res;
            if (byte_pos == 0 && b != HeaderByte)
                return;
            if (byte_pos >= CheckPos)
            begin
                if (b == frame_sum)
                begin
                    case (frame_bytes[0])
                        TypeAccel: res.frame_kind = KIND_ACCEL;
                        TypeRate:  res.frame_kind = KIND_RATE;
                        TypeAngle: res.frame_kind = KIND_ANGLE;
                        default:   res.frame_kind = KIND_OTHER;
                    endcase
                    res.type_byte = frame_bytes[0];
                    res.axis_x    = {frame_bytes[2], frame_bytes[1]};
                    res.axis_y    = {frame_bytes[4], frame_bytes[3]};
                    res.axis_z    = {frame_bytes[6], frame_bytes[5]};
                    res.temp_raw  = {frame_bytes[8], frame_bytes[7]};
                    expected_frames.push_back(res);
                end
                byte_pos  = '0;
                frame_sum = '0;
                return;
            end
            frame_sum = frame_sum + b;
            if (byte_pos >= 1)
                frame_bytes[byte_pos - 1] = b;
            byte_pos = byte_pos + 1;
        endfunction

        // compare one delivered frame with the oldest one due
        function void check_frame(frame_res_t got);
            frame_res_t exp;
            if (expected_frames.size() == 0)
            begin
                $error("unexpected frame: kind %0d type %02h", got.frame_kind, got.type_byte);
                mismatches++;
                return;
            end
            exp = expected_frames.pop_front();
            if (got.frame_kind !== exp.frame_kind)
            begin
                $error("frame_kind expected %0d got %0d", exp.frame_kind, got.frame_kind);
                mismatches++;
            end
            if (got.type_byte !== exp.type_byte)
            begin
                $error("type_byte expected %02h got %02h", exp.type_byte, got.type_byte);
                mismatches++;
            end
            if (got.axis_x !== exp.axis_x)
            begin
                $error("axis_x expected %0d got %0d", exp.axis_x, got.axis_x);
                mismatches++;
            end
            if (got.axis_y !== exp.axis_y)
            begin
                $error("axis_y expected %0d got %0d", exp.axis_y, got.axis_y);
                mismatches++;
            end
            if (got.axis_z !== exp.axis_z)
            begin
                $error("axis_z expected %0d got %0d", exp.axis_z, got.axis_z);
                mismatches++;
            end
            if (got.temp_raw !== exp.temp_raw)
            begin
                $error("temp_raw expected %0d got %0d", exp.temp_raw, got.temp_raw);
                mismatches++;
            end
        endfunction

        function int frames_due();
            return expected_frames.size();
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte   = 8'h00;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         frame_kind;
    logic [7:0]         type_byte;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] temp_raw;

    frame_checker checker_h = new();

    int          burst_left       = 0;
    int          frame_bytes_sent = 0;
    logic [15:0] ready_pattern    = 16'hFFFF;
    int          pattern_age      = 0;

    imu_frame_parser i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_kind (frame_kind),
        .type_byte  (type_byte),
        .axis_x     (axis_x),
        .axis_y     (axis_y),
        .axis_z     (axis_z),
        .temp_raw   (temp_raw)
    );

    always #5 clk = ~clk;

    // watch both channels at the clock edge
    always @(posedge clk)
    begin
        frame_res_t got;
        if (rst_n && in_valid && in_ready)
            checker_h.note_rx_byte(rx_byte);
        if (rst_n && out_valid && out_ready)
        begin
            got.frame_kind = frame_kind_t'(frame_kind);
            got.type_byte  = type_byte;
            got.axis_x     = axis_x;
            got.axis_y     = axis_y;
            got.axis_z     = axis_z;
            got.temp_raw   = temp_raw;
            checker_h.check_frame(got);
        end
    end

    // receiver stalls: a rotating pattern, replaced now and then, sometimes always ready
    always @(posedge clk)
    begin
        if (pattern_age == 0)
        begin
            pattern_age   <= $urandom_range(20, 150);
            ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            out_ready     <= 1'b1;
        end
        else
        begin
            pattern_age   <= pattern_age - 1;
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
            out_ready     <= ready_pattern[0];
        end
    end

    // offer one byte and hold it until taken; gaps fall between bursts
    task automatic push_byte(input logic [7:0] b);
        int gap;
        rx_byte  <= b;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // build an 11-byte frame and send its first send_len bytes
    task automatic send_frame(input logic [7:0] type_b, input logic [63:0] body,
                              input bit corrupt, input int send_len);
        logic [7:0] frame_b [11];
        logic [7:0] sum;
        frame_b[0] = HeaderByte;
        frame_b[1] = type_b;
        for (int i = 0; i < 8; i++)
            frame_b[2 + i] = body[8*i +: 8];
        sum = '0;
        for (int i = 0; i < 10; i++)
            sum = sum + frame_b[i];
        frame_b[10] = corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        for (int i = 0; i < send_len; i++)
            push_byte(frame_b[i]);
        frame_bytes_sent += send_len;
    endtask

    initial
    begin
        int          pick;
        logic [7:0]  type_b;
        logic [7:0]  noise;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: noise while hunting, field extremes, header bytes as data, bad checksum
        push_byte(8'h00);
        push_byte(8'hFF);
        send_frame(TypeAccel, {16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000}, 1'b0, 11);
        send_frame(TypeAngle, 64'h5555_5555_5555_5555, 1'b0, 11);
        send_frame(TypeRate, 64'h5555_0055_5500_5555, 1'b1, 11);
        send_frame(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 11);

        // random: mostly well-formed frames, some corrupt, noise and cut-off frames
        while (frame_bytes_sent < 2000)
        begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0:       type_b = TypeAccel;
                1:       type_b = TypeRate;
                2:       type_b = TypeAngle;
                default: type_b = 8'($urandom);
            endcase
            if (pick < 72)
                send_frame(type_b, {$urandom, $urandom}, 1'b0, 11);
            else if (pick < 84)
                send_frame(type_b, {$urandom, $urandom}, 1'b1, 11);
            else if (pick < 94)
            begin
                noise = 8'($urandom);
                if (noise == HeaderByte && $urandom_range(0, 1) == 0)
                    noise = 8'hAA;
                push_byte(noise);
            end
            else
            begin
                // cut-off frame, padded so the parser finishes it and returns to hunting
                send_frame(type_b, {$urandom, $urandom}, 1'b0, $urandom_range(1, 10));
                repeat (10) push_byte(8'h00);
            end
        end

        // the last byte has been taken, so drop valid right away
        in_valid <= 1'b0;
        while (checker_h.frames_due() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (checker_h.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
